// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ipfd_pkg.sv =====
package ipfd_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned CODE_W = 16;
   localparam int unsigned CSR_W  = 16;
   localparam int unsigned COUNT_W = 5;

   localparam int unsigned FRAME_START_MAX_DEFAULT = 10000;

   // timer wrap guard
   localparam logic [TIME_W-1:0] WRAP_LIMIT  = 32'hFFFF_FF00;
   localparam logic [TIME_W-1:0] WRAP_ADJUST = 32'h0000_0100;

   localparam logic [COUNT_W-1:0] WORD_SPLIT_COUNT = 5'd9;
   localparam logic [COUNT_W-1:0] FRAME_END_COUNT  = 5'd18;

   typedef enum logic [2:0] {
      CSR_FRAME_START_MIN = 3'd0,
      CSR_WORD_START_MIN  = 3'd1,
      CSR_WORD_START_MAX  = 3'd2,
      CSR_TIMING_MIN      = 3'd3,
      CSR_TIMING_MAX      = 3'd4,
      CSR_BIT_MIN         = 3'd5,
      CSR_BIT_MAX         = 3'd6,
      CSR_ONE_MIN         = 3'd7
   } csr_index_type;

   localparam logic [CSR_W-1:0] FRAME_START_MIN_RST = 16'd6000;
   localparam logic [CSR_W-1:0] WORD_START_MIN_RST  = 16'd3000;
   localparam logic [CSR_W-1:0] WORD_START_MAX_RST  = 16'd5000;
   localparam logic [CSR_W-1:0] TIMING_MIN_RST      = 16'd300;
   localparam logic [CSR_W-1:0] TIMING_MAX_RST      = 16'd800;
   localparam logic [CSR_W-1:0] BIT_MIN_RST         = 16'd300;
   localparam logic [CSR_W-1:0] BIT_MAX_RST         = 16'd2000;
   localparam logic [CSR_W-1:0] ONE_MIN_RST         = 16'd1000;

   typedef struct packed {
      logic [CSR_W-1:0] frame_start_min;
      logic [CSR_W-1:0] word_start_min;
      logic [CSR_W-1:0] word_start_max;
      logic [CSR_W-1:0] timing_min;
      logic [CSR_W-1:0] timing_max;
      logic [CSR_W-1:0] bit_min;
      logic [CSR_W-1:0] bit_max;
      logic [CSR_W-1:0] one_min;
   } csr_type;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
   } result_type;

endpackage

// ===== rtl/ipfd_csr.sv =====
module ipfd_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_en,
   input  ipfd_pkg::csr_index_type csr_index,
   input  logic [15:0]             csr_wdata,
   output ipfd_pkg::csr_type       csr
);
   import ipfd_pkg::*;

   csr_type csr_ff;
   csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FRAME_START_MIN: csr_in.frame_start_min = csr_wdata;
            CSR_WORD_START_MIN:  csr_in.word_start_min  = csr_wdata;
            CSR_WORD_START_MAX:  csr_in.word_start_max  = csr_wdata;
            CSR_TIMING_MIN:      csr_in.timing_min      = csr_wdata;
            CSR_TIMING_MAX:      csr_in.timing_max      = csr_wdata;
            CSR_BIT_MIN:         csr_in.bit_min         = csr_wdata;
            CSR_BIT_MAX:         csr_in.bit_max         = csr_wdata;
            CSR_ONE_MIN:         csr_in.one_min         = csr_wdata;
            default:             csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.frame_start_min <= FRAME_START_MIN_RST;
         csr_ff.word_start_min  <= WORD_START_MIN_RST;
         csr_ff.word_start_max  <= WORD_START_MAX_RST;
         csr_ff.timing_min      <= TIMING_MIN_RST;
         csr_ff.timing_max      <= TIMING_MAX_RST;
         csr_ff.bit_min         <= BIT_MIN_RST;
         csr_ff.bit_max         <= BIT_MAX_RST;
         csr_ff.one_min         <= ONE_MIN_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

// ===== rtl/ipfd_core.sv =====
module ipfd_core #(
   parameter int unsigned FRAME_START_MAX = ipfd_pkg::FRAME_START_MAX_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [31:0]          edge_time,
   input  logic                 line_level,
   input  ipfd_pkg::csr_type    csr,
   output ipfd_pkg::result_type result
);
   import ipfd_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_SOF  = 3'd1,
      PH_SOW  = 3'd2,
      PH_TIM  = 3'd3,
      PH_BIT  = 3'd4
   } phase_type;

   localparam logic [TIME_W-1:0] FrameMax = TIME_W'(FRAME_START_MAX);

   phase_type          phase_ff, phase_in;
   logic               prev_level_ff, prev_level_in;
   logic [TIME_W-1:0]  prev_time_ff, prev_time_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CODE_W-1:0]  code_ff, code_in;

   logic [TIME_W-1:0]  width_raw;
   logic               wrap;
   logic [TIME_W-1:0]  width;
   logic [TIME_W-1:0]  now;
   logic [COUNT_W-1:0] count_inc;
   logic               level_change;

   assign level_change = line_level != prev_level_ff;
   assign width_raw    = edge_time - prev_time_ff;
   assign wrap         = width_raw >= WRAP_LIMIT;
   assign width        = wrap ? width_raw + WRAP_ADJUST : width_raw;
   assign now          = wrap ? edge_time + WRAP_ADJUST : edge_time;
   assign count_inc    = count_ff + 1'b1;

   always_comb begin
      phase_in      = phase_ff;
      prev_level_in = prev_level_ff;
      prev_time_in  = prev_time_ff;
      count_in      = count_ff;
      code_in       = code_ff;
      result.valid  = 1'b0;
      result.code   = code_ff;
      if (fire && level_change) begin
         prev_level_in = line_level;
         prev_time_in  = now;
         phase_in      = PH_IDLE;
         if (line_level) begin
            // rising edge closes a low pulse
            if (phase_ff == PH_SOF) begin
               if (width > 32'(csr.frame_start_min) && width < FrameMax) begin
                  phase_in = PH_SOW;
                  code_in  = '0;
                  count_in = '0;
               end
            end else if (phase_ff == PH_TIM) begin
               if (width > 32'(csr.timing_min) && width < 32'(csr.timing_max)) begin
                  count_in = count_inc;
                  if (count_inc == WORD_SPLIT_COUNT) begin
                     phase_in = PH_SOW;
                  end else if (count_inc < FRAME_END_COUNT) begin
                     phase_in = PH_BIT;
                  end else if (count_inc == FRAME_END_COUNT) begin
                     result.valid = 1'b1;
                  end
               end
            end
         end else begin
            // falling edge closes a high pulse
            if (phase_ff == PH_IDLE) begin
               phase_in = PH_SOF;
            end else if (phase_ff == PH_SOW) begin
               if (width > 32'(csr.word_start_min) && width < 32'(csr.word_start_max)) begin
                  phase_in = PH_TIM;
               end
            end else if (phase_ff == PH_BIT) begin
               if (width >= 32'(csr.bit_min) && width < 32'(csr.bit_max)) begin
                  code_in  = {code_ff[CODE_W-2:0], width > 32'(csr.one_min)};
                  phase_in = PH_TIM;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         prev_level_ff <= 1'b1;
         prev_time_ff  <= '0;
         count_ff      <= '0;
         code_ff       <= '0;
      end else begin
         phase_ff      <= phase_in;
         prev_level_ff <= prev_level_in;
         prev_time_ff  <= prev_time_in;
         count_ff      <= count_in;
         code_ff       <= code_in;
      end
   end

endmodule

// ===== rtl/ipfd_out_stage.sv =====
module ipfd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  ipfd_pkg::result_type result,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [15:0]          rsp_frame_code
);
   import ipfd_pkg::*;

   logic              valid_ff, valid_in;
   logic [CODE_W-1:0] code_ff, code_in;

   always_comb begin
      valid_in = valid_ff;
      code_in  = code_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      // core only fires when this register is free or draining
      if (fire && result.valid) begin
         valid_in = 1'b1;
         code_in  = result.code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      code_ff <= code_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_frame_code = code_ff;

endmodule

// ===== rtl/ir_pulse_frame_decoder.sv =====
// Infrared pulse-distance frame decoder. One word per line edge (timestamp
// and new pin level); a full frame of 16 data bits comes out as one 16-bit
// code. An edge is taken every clock cycle unless the result side stalls:
// the pulse width subtraction, the window compares and the phase update are
// combinational between the input register and the result register, so the
// sustained rate is one edge per cycle without stalls, and a code reaches
// rsp_ from the result register. While a finished code waits on a stalled
// result side the input register can still take one edge; req_stall rises
// only once both hold a word. Thresholds are written through the csr_ port
// while no frame is in flight; FRAME_START_MAX bounds the start-of-frame pulse.
module ir_pulse_frame_decoder #(
   parameter int unsigned FRAME_START_MAX = ipfd_pkg::FRAME_START_MAX_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [31:0]             req_edge_time,
   input  logic                    req_line_level,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [15:0]             rsp_frame_code,
   input  logic                    csr_write_en,
   input  ipfd_pkg::csr_index_type csr_index,
   input  logic [15:0]             csr_wdata
);
   import ipfd_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [TIME_W-1:0] in_time_ff, in_time_in;
   logic              in_level_ff, in_level_in;
   logic              fire;
   logic              accept;
   csr_type           csr;
   result_type        result;

   assign fire      = in_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_time_in  = in_time_ff;
      in_level_in = in_level_ff;
      if (fire) begin
         in_valid_in = 1'b0;
      end
      if (accept) begin
         in_valid_in = 1'b1;
         in_time_in  = req_edge_time;
         in_level_in = req_line_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_time_ff  <= in_time_in;
      in_level_ff <= in_level_in;
   end

   ipfd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .csr          (csr)
   );

   ipfd_core #(
      .FRAME_START_MAX (FRAME_START_MAX)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .edge_time  (in_time_ff),
      .line_level (in_level_ff),
      .csr        (csr),
      .result     (result)
   );

   ipfd_out_stage u_out (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .result         (result),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_code (rsp_frame_code)
   );

endmodule

// ===== rtl/ipfd_checker.sv =====
`include "assert_macros.svh"

module ipfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_frame_code
);

   // both stages empty after reset
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!rsp_valid && !req_stall), "not empty after reset")

   // input side only backs up when a code is stuck on the result side
   `ASSERT_CLK(a_stall_cause, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "stall without blocked result")

   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_frame_code)), "result word dropped or changed")

endmodule

bind ir_pulse_frame_decoder ipfd_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_frame_code (rsp_frame_code)
);
